// File: sv/tbp_pkg.sv
// Shared types, constants and helper functions for the tournament branch predictor.
// No dependencies; every other file refers to this package by scoped names.
package tbp_pkg;

    localparam int CTR_W             = 3;
    localparam int CFG_W             = 3;
    localparam int IDX_W             = 4;
    localparam int TALLY_W           = 32;
    localparam int CFG_IDX_W         = 1;
    localparam int LOCAL_ENTRIES_DEF = 16;
    localparam int HISTORY_BITS_DEF  = 6;

    localparam logic [CFG_W-1:0] CEILING_RESET   = 3'd4;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNTER_CEILING = 1'b0,
        CFG_TAKEN_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic               local_predicts_taken;
        logic               global_predicts_taken;
        logic               chose_global;
        logic               final_predicts_taken;
        logic               final_correct;
        logic [TALLY_W-1:0] local_hits;
        logic [TALLY_W-1:0] global_hits;
        logic [TALLY_W-1:0] final_hits;
    } result_t;

    // Saturating counter step toward the outcome; a counter above the ceiling clamps on up.
    function automatic logic [CTR_W-1:0] train(input logic [CTR_W-1:0] c,
                                               input logic             up,
                                               input logic [CFG_W-1:0] ceiling);
        logic [CTR_W-1:0] r;
        if (up) begin
            if (c >= ceiling)
                r = ceiling;
            else
                r = c + CTR_W'(1);
        end
        else begin
            if (c != '0)
                r = c - CTR_W'(1);
            else
                r = '0;
        end
        return r;
    endfunction

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] t);
        logic [TALLY_W-1:0] r;
        if (t == '1)
            r = t;
        else
            r = t + TALLY_W'(1);
        return r;
    endfunction

endpackage

// File: sv/tbp_if.sv
// Valid/ready channel interfaces for branch words and result words.
// Depends on tbp_pkg for field widths.
interface tbp_in_if;
    logic                      valid;
    logic                      ready;
    logic [tbp_pkg::IDX_W-1:0] branch_index;
    logic                      taken;

    modport source (output valid, output branch_index, output taken, input ready);
    modport sink   (input valid, input branch_index, input taken, output ready);
endinterface

interface tbp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        local_predicts_taken;
    logic                        global_predicts_taken;
    logic                        chose_global;
    logic                        final_predicts_taken;
    logic                        final_correct;
    logic [tbp_pkg::TALLY_W-1:0] local_hits;
    logic [tbp_pkg::TALLY_W-1:0] global_hits;
    logic [tbp_pkg::TALLY_W-1:0] final_hits;

    modport source (output valid, output local_predicts_taken, output global_predicts_taken,
                    output chose_global, output final_predicts_taken, output final_correct,
                    output local_hits, output global_hits, output final_hits,
                    input ready);
    modport sink   (input valid, input local_predicts_taken, input global_predicts_taken,
                    input chose_global, input final_predicts_taken, input final_correct,
                    input local_hits, input global_hits, input final_hits,
                    output ready);
endinterface

// File: sv/tbp_global_table.sv
// Global history counter table: a memory with registered read at the next history,
// per-entry valid bits for reset, and a bypass when read and write hit the same entry.
// Depends on tbp_pkg.
module tbp_global_table #(
    parameter int HISTORY_BITS = tbp_pkg::HISTORY_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      upd,
    input  logic [HISTORY_BITS-1:0]   wr_addr,
    input  logic [tbp_pkg::CTR_W-1:0] wr_data,
    input  logic [HISTORY_BITS-1:0]   rd_addr,
    output logic [tbp_pkg::CTR_W-1:0] cur
);

    localparam int ENTRIES = 1 << HISTORY_BITS;

    logic [tbp_pkg::CTR_W-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]        valid_reg;
    logic [tbp_pkg::CTR_W-1:0] rd_data_reg;
    logic                      rd_valid_reg;
    logic                      byp_reg;
    logic [tbp_pkg::CTR_W-1:0] byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            mem[wr_addr] <= wr_data;
            rd_data_reg  <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            byp_data_reg <= '0;
        end
        else if (upd)
        begin
            valid_reg[wr_addr] <= 1'b1;
            rd_valid_reg       <= valid_reg[rd_addr];
            byp_reg            <= (rd_addr == wr_addr);
            byp_data_reg       <= wr_data;
        end
    end

    // Never-written entries read as zero
    assign cur = byp_reg ? byp_data_reg : (rd_valid_reg ? rd_data_reg : '0);

endmodule

// File: sv/tbp_result_buf.sv
// Two-entry result buffer: output register plus skid register on the result channel.
// Depends on tbp_pkg and tbp_if.
module tbp_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tbp_pkg::result_t     push_data,
    output logic                 can_push,
    tbp_out_if.source            result
);

    tbp_pkg::result_t head_reg;
    tbp_pkg::result_t skid_reg;
    logic             head_valid_reg;
    logic             skid_valid_reg;
    logic             pop;

    assign pop      = head_valid_reg & result.ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= push;
            else
                head_valid_reg <= push;
        end
        else if (!head_valid_reg)
            head_valid_reg <= push;
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                skid_reg <= push_data;
            end
            else
                head_reg <= push_data;
        end
        else if (!head_valid_reg)
            head_reg <= push_data;
        else if (push)
            skid_reg <= push_data;
    end

    assign result.valid                 = head_valid_reg;
    assign result.local_predicts_taken  = head_reg.local_predicts_taken;
    assign result.global_predicts_taken = head_reg.global_predicts_taken;
    assign result.chose_global          = head_reg.chose_global;
    assign result.final_predicts_taken  = head_reg.final_predicts_taken;
    assign result.final_correct         = head_reg.final_correct;
    assign result.local_hits            = head_reg.local_hits;
    assign result.global_hits           = head_reg.global_hits;
    assign result.final_hits            = head_reg.final_hits;

endmodule

// File: sv/tournament_branch_predictor.sv
// Tournament branch predictor: local, global-history and chooser counters, hit tallies.
// Throughput: one branch word per cycle while the result buffer's skid register is free;
// a two-entry result buffer absorbs output stalls.
// The global counter is read ahead at the next history, with same-entry bypass.
// Reset clears all tables (global table through per-entry valid bits), history and tallies
// at once, and loads the registers with ceiling 4 and threshold 1; no clearing pass.
module tournament_branch_predictor #(
    parameter int LOCAL_ENTRIES = tbp_pkg::LOCAL_ENTRIES_DEF,
    parameter int HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tbp_in_if.sink                        branch,
    tbp_out_if.source                     result,
    input  logic                          cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]     cfg_data
);

    localparam int LI_W      = $clog2(LOCAL_ENTRIES);
    localparam int IDX_RANGE = 1 << tbp_pkg::IDX_W;

    logic [tbp_pkg::CTR_W-1:0]   local_tbl_reg   [LOCAL_ENTRIES];
    logic [tbp_pkg::CTR_W-1:0]   chooser_tbl_reg [LOCAL_ENTRIES];
    logic [HISTORY_BITS-1:0]     hist_reg;
    logic [HISTORY_BITS:0]       hist_shift;
    logic [HISTORY_BITS-1:0]     hist_next;
    logic [tbp_pkg::TALLY_W-1:0] local_tally_reg;
    logic [tbp_pkg::TALLY_W-1:0] global_tally_reg;
    logic [tbp_pkg::TALLY_W-1:0] final_tally_reg;
    logic [tbp_pkg::TALLY_W-1:0] local_tally_next;
    logic [tbp_pkg::TALLY_W-1:0] global_tally_next;
    logic [tbp_pkg::TALLY_W-1:0] final_tally_next;
    logic [tbp_pkg::CFG_W-1:0]   ceiling_reg;
    logic [tbp_pkg::CFG_W-1:0]   threshold_reg;

    logic [LI_W-1:0]             li;
    logic [tbp_pkg::CTR_W-1:0]   l_ctr;
    logic [tbp_pkg::CTR_W-1:0]   g_ctr;
    logic [tbp_pkg::CTR_W-1:0]   c_ctr;
    logic [tbp_pkg::CTR_W-1:0]   l_trained;
    logic [tbp_pkg::CTR_W-1:0]   g_trained;
    logic [tbp_pkg::CTR_W-1:0]   c_trained;
    logic                        lp;
    logic                        gp;
    logic                        cg;
    logic                        fp;
    logic                        fc;
    logic                        accept;
    logic                        can_push;
    tbp_pkg::result_t            res;

    // Fold the branch index onto the local tables
    always_comb
    begin
        li = '0;
        for (int k = 0; k < IDX_RANGE; k++)
        begin
            if (branch.branch_index == tbp_pkg::IDX_W'(k))
                li = LI_W'(k % LOCAL_ENTRIES);
        end
    end

    assign branch.ready = can_push;
    assign accept       = branch.valid & can_push;

    assign l_ctr = local_tbl_reg[li];
    assign c_ctr = chooser_tbl_reg[li];

    assign lp = l_ctr > threshold_reg;
    assign gp = g_ctr > threshold_reg;
    assign cg = c_ctr > threshold_reg;
    assign fp = cg ? gp : lp;
    assign fc = (fp == branch.taken);

    assign l_trained = tbp_pkg::train(l_ctr, branch.taken, ceiling_reg);
    assign g_trained = tbp_pkg::train(g_ctr, branch.taken, ceiling_reg);
    assign c_trained = tbp_pkg::train(c_ctr, gp == branch.taken, ceiling_reg);

    assign hist_shift = {hist_reg, branch.taken};
    assign hist_next  = hist_shift[HISTORY_BITS-1:0];

    assign local_tally_next  = (lp == branch.taken) ? tbp_pkg::sat_inc(local_tally_reg)
                                                    : local_tally_reg;
    assign global_tally_next = (gp == branch.taken) ? tbp_pkg::sat_inc(global_tally_reg)
                                                    : global_tally_reg;
    assign final_tally_next  = fc ? tbp_pkg::sat_inc(final_tally_reg) : final_tally_reg;

    tbp_global_table #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_gtbl (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (accept),
        .wr_addr (hist_reg),
        .wr_data (g_trained),
        .rd_addr (hist_next),
        .cur     (g_ctr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOCAL_ENTRIES; i++)
            begin
                local_tbl_reg[i]   <= '0;
                chooser_tbl_reg[i] <= '0;
            end
            hist_reg         <= '0;
            local_tally_reg  <= '0;
            global_tally_reg <= '0;
            final_tally_reg  <= '0;
        end
        else if (accept)
        begin
            local_tbl_reg[li] <= l_trained;
            // Train the chooser only when the two guesses disagree
            if (lp != gp)
                chooser_tbl_reg[li] <= c_trained;
            hist_reg         <= hist_next;
            local_tally_reg  <= local_tally_next;
            global_tally_reg <= global_tally_next;
            final_tally_reg  <= final_tally_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg   <= tbp_pkg::CEILING_RESET;
            threshold_reg <= tbp_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbp_pkg::CFG_COUNTER_CEILING: ceiling_reg   <= cfg_data;
                tbp_pkg::CFG_TAKEN_THRESHOLD: threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.local_predicts_taken  = lp;
        res.global_predicts_taken = gp;
        res.chose_global          = cg;
        res.final_predicts_taken  = fp;
        res.final_correct         = fc;
        res.local_hits            = local_tally_next;
        res.global_hits           = global_tally_next;
        res.final_hits            = final_tally_next;
    end

    tbp_result_buf u_rbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .can_push  (can_push),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted branch word left no result word");

    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (hist_reg[0] == $past(branch.taken)))
        else $error("history did not shift in the outcome");

    a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (final_tally_reg >= $past(final_tally_reg))
        && (local_tally_reg >= $past(local_tally_reg)))
        else $error("hit tally decreased");
`endif

endmodule
